@@ rtl/smms_pkg.sv @@
// Shared types and constants for the sparkline min/max scaler.
package smms_pkg;

	localparam int SAMPLE_W  = 8;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 8;
	localparam int IDX_W     = 6;
	localparam int X_W       = 14;
	localparam int Y_W       = 9;
	localparam int PROD_W    = 2 * SAMPLE_W;
	localparam int DCNT_W    = 4;

	localparam int DEF_HISTORY_DEPTH = 10;

	localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_X_STEP   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_Y_BASE   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_Y_SPAN   = CFG_IDX_W'(3);

	localparam logic [CFG_W-1:0] RST_X_ORIGIN = CFG_W'(3);
	localparam logic [CFG_W-1:0] RST_X_STEP   = CFG_W'(6);
	localparam logic [CFG_W-1:0] RST_Y_BASE   = CFG_W'(36);
	localparam logic [CFG_W-1:0] RST_Y_SPAN   = CFG_W'(31);

	typedef struct packed {
		logic             shift_in;
		logic             scan;
		logic             scan_first;
		logic             mul;
		logic             div;
		logic             emit;
		logic             last_pt;
		logic [IDX_W-1:0] idx;
	} smms_cmd_t;

endpackage

@@ rtl/smms_ctrl.sv @@
// Sequencer for the sparkline scaler: scan, multiply, divide and emit phases.
module smms_ctrl import smms_pkg::*; #(
	parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	output smms_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MUL,
		ST_DIV,
		ST_LOAD,
		ST_OUT
	} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);
	localparam logic [DCNT_W-1:0] LAST_DIV = '1;

	state_t             state_q;
	logic [IDX_W-1:0]   cnt_q;
	logic [DCNT_W-1:0]  dcnt_q;
	logic               in_acc;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign in_acc    = in_valid && (state_q == ST_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.idx        = cnt_q;
		cmd.last_pt    = (cnt_q == LAST_IDX);
		cmd.shift_in   = in_acc;
		cmd.scan       = (state_q == ST_SCAN);
		cmd.scan_first = (state_q == ST_SCAN) && (cnt_q == '0);
		cmd.mul        = (state_q == ST_MUL);
		cmd.div        = (state_q == ST_DIV);
		cmd.emit       = (state_q == ST_LOAD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			dcnt_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
					end
				end
				ST_SCAN: begin
					if (cnt_q == LAST_IDX) begin
						state_q <= ST_MUL;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
					dcnt_q  <= '0;
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == LAST_DIV) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_stall) begin
						if (cnt_q == LAST_IDX) begin
							state_q <= ST_IDLE;
							cnt_q   <= '0;
						end else begin
							state_q <= ST_MUL;
							cnt_q   <= cnt_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/smms_dp.sv @@
// Datapath: history ring, min/max scan, scaler multiply, restoring divider, output words.
module smms_dp import smms_pkg::*; #(
	parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  smms_cmd_t             cmd,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic [SAMPLE_W-1:0]   sample,
	output logic [IDX_W-1:0]      point_index,
	output logic [X_W-1:0]        x_pos,
	output logic signed [Y_W-1:0] y_pos,
	output logic                  last_point
);

	logic [SAMPLE_W-1:0] hist_q [HISTORY_DEPTH];
	logic [CFG_W-1:0]    x_origin_q, x_step_q, y_base_q, y_span_q;
	logic [SAMPLE_W-1:0] lo_q, hi_q, range_q, rem_q;
	logic [PROD_W-1:0]   dq_q;
	logic [X_W-1:0]      x_acc_q;
	logic [SAMPLE_W-1:0] head, offset;
	logic [SAMPLE_W:0]   trial;
	logic                fits;

	assign head   = hist_q[0];
	assign offset = head - lo_q;
	assign trial  = {rem_q, dq_q[PROD_W-1]};
	assign fits   = (trial >= {1'b0, range_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin_q <= RST_X_ORIGIN;
			x_step_q   <= RST_X_STEP;
			y_base_q   <= RST_Y_BASE;
			y_span_q   <= RST_Y_SPAN;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_X_ORIGIN: x_origin_q <= cfg_data;
				REG_X_STEP:   x_step_q   <= cfg_data;
				REG_Y_BASE:   y_base_q   <= cfg_data;
				REG_Y_SPAN:   y_span_q   <= cfg_data;
				default:      ;
			endcase
		end
	end

	// history: shift in at the newest end, rotate during scan and per point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
		end else if (cmd.shift_in || cmd.scan || cmd.mul) begin
			for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
				hist_q[i] <= hist_q[i+1];
			end
			hist_q[HISTORY_DEPTH-1] <= cmd.shift_in ? sample : head;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			if (cmd.scan_first || head < lo_q) begin
				lo_q <= head;
			end
			if (cmd.scan_first || head > hi_q) begin
				hi_q <= head;
			end
			if (cmd.scan_first) begin
				x_acc_q <= X_W'(x_origin_q);
			end
		end
		if (cmd.mul) begin
			dq_q    <= offset * y_span_q;
			rem_q   <= '0;
			range_q <= (hi_q == lo_q) ? SAMPLE_W'(1) : hi_q - lo_q;
		end
		if (cmd.div) begin
			rem_q <= fits ? SAMPLE_W'(trial - {1'b0, range_q}) : trial[SAMPLE_W-1:0];
			dq_q  <= {dq_q[PROD_W-2:0], fits};
		end
		if (cmd.emit) begin
			point_index <= cmd.idx;
			x_pos       <= x_acc_q;
			y_pos       <= {1'b0, y_base_q} - {1'b0, dq_q[SAMPLE_W-1:0]};
			last_point  <= cmd.last_pt;
			x_acc_q     <= x_acc_q + X_W'(x_step_q);
		end
	end

endmodule

@@ rtl/sparkline_min_max_scaler_unit.sv @@
// Top level of the sparkline min/max scaler.
// Usage:
//   Input channel (in_valid/in_stall/sample): one 8-bit rate sample per word.
//   in_stall is high from acceptance until the last point of that sample's
//   run has been taken; one sample is processed at a time.
//   Output channel (out_valid/out_stall): HISTORY_DEPTH point words per
//   sample, oldest first, last_point set on the newest one.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): cfg_ready is
//   always high; indexes 0..3 are x_origin, x_step, y_base, y_span, others
//   are dropped. Write only while idle.
// Timing: after a sample is taken the history is scanned for min/max,
//   one entry per cycle. Each point then passes through a multiply step,
//   the bit-serial divider and a load step before its word is valid;
//   the next point starts only once the previous one has been taken.
// Stall: a stalled output word holds; the sequencer waits in place.
// Reset: history clears to zero, registers return to 3, 6, 36, 31.
module sparkline_min_max_scaler_unit import smms_pkg::*; #(
	parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [SAMPLE_W-1:0]   sample,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [IDX_W-1:0]      point_index,
	output logic [X_W-1:0]        x_pos,
	output logic signed [Y_W-1:0] y_pos,
	output logic                  last_point,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	smms_cmd_t cmd;

	assign cfg_ready = 1'b1;

	smms_ctrl #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd)
	);

	smms_dp #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample     (sample),
		.point_index(point_index),
		.x_pos      (x_pos),
		.y_pos      (y_pos),
		.last_point (last_point)
	);

endmodule
